// ===== sv/lun_pkg.sv =====
// Package for the Newton lens undistortion block: value types, micro-op codes,
// operand codes, fixed-point constants and the per-iteration microprogram.
// No dependencies.
package lun_pkg;

    typedef logic signed [63:0] t_val;
    typedef logic [2:0]         t_op;
    typedef logic [5:0]         t_src;
    typedef logic [6:0]         t_pc;
    typedef logic [2:0]         t_cfg_idx;

    localparam int unsigned ITER_LIMIT     = 100;
    localparam int unsigned RAM_DEPTH      = 32;
    localparam int unsigned RAM_AW         = $clog2(RAM_DEPTH);

    localparam t_val WMAX  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam t_val Q_ONE = 64'sd268435456;
    localparam t_val Q_C2  = 64'sd536870912;
    localparam t_val Q_C3  = 64'sd805306368;
    localparam t_val Q_C6  = 64'sd1610612736;

    localparam t_cfg_idx CFG_K1  = 3'd0;
    localparam t_cfg_idx CFG_K2  = 3'd1;
    localparam t_cfg_idx CFG_K3  = 3'd2;
    localparam t_cfg_idx CFG_P1  = 3'd3;
    localparam t_cfg_idx CFG_P2  = 3'd4;
    localparam t_cfg_idx CFG_THR = 3'd5;

    localparam t_op OP_MUL = 3'd0;
    localparam t_op OP_ADD = 3'd1;
    localparam t_op OP_SUB = 3'd2;
    localparam t_op OP_DIV = 3'd3;
    localparam t_op OP_BRZ = 3'd4;
    localparam t_op OP_UPD = 3'd5;

    localparam t_src T_X2  = 6'd0;
    localparam t_src T_Y2  = 6'd1;
    localparam t_src T_XY  = 6'd2;
    localparam t_src T_R2  = 6'd3;
    localparam t_src T_R4  = 6'd4;
    localparam t_src T_A   = 6'd5;
    localparam t_src T_T   = 6'd6;
    localparam t_src T_KR  = 6'd7;
    localparam t_src T_B   = 6'd8;
    localparam t_src T_DKR = 6'd9;
    localparam t_src T_C   = 6'd10;
    localparam t_src T_JA  = 6'd11;
    localparam t_src T_JB  = 6'd12;
    localparam t_src T_JD  = 6'd13;
    localparam t_src T_F   = 6'd14;
    localparam t_src T_G   = 6'd15;
    localparam t_src T_DET = 6'd16;
    localparam t_src T_DX  = 6'd17;
    localparam t_src T_DY  = 6'd18;
    localparam t_src S_X   = 6'd32;
    localparam t_src S_Y   = 6'd33;
    localparam t_src S_X0  = 6'd34;
    localparam t_src S_Y0  = 6'd35;
    localparam t_src S_K1  = 6'd36;
    localparam t_src S_K2  = 6'd37;
    localparam t_src S_K3  = 6'd38;
    localparam t_src S_P1  = 6'd39;
    localparam t_src S_P2  = 6'd40;
    localparam t_src S_ONE = 6'd41;
    localparam t_src S_C2  = 6'd42;
    localparam t_src S_C3  = 6'd43;
    localparam t_src S_C6  = 6'd44;

    typedef struct packed {
        t_op               op;
        logic [RAM_AW-1:0] dst;
        t_src              sa;
        t_src              sb;
    } t_instr;

    typedef struct packed {
        logic start;
        t_op  op;
        t_val a;
        t_val b;
    } t_alu_req;

    function automatic t_instr mk(t_op op, t_src d, t_src a, t_src b);
        t_instr i;
        i.op  = op;
        i.dst = d[RAM_AW-1:0];
        i.sa  = a;
        i.sb  = b;
        return i;
    endfunction

    function automatic t_instr prog(t_pc pc);
        t_instr i;
        case (pc)
            7'd0:  i = mk(OP_MUL, T_X2,  S_X,   S_X);
            7'd1:  i = mk(OP_MUL, T_Y2,  S_Y,   S_Y);
            7'd2:  i = mk(OP_MUL, T_XY,  S_X,   S_Y);
            7'd3:  i = mk(OP_ADD, T_R2,  T_X2,  T_Y2);
            7'd4:  i = mk(OP_MUL, T_R4,  T_R2,  T_R2);
            7'd5:  i = mk(OP_MUL, T_A,   T_R2,  S_K3);
            7'd6:  i = mk(OP_ADD, T_T,   S_K2,  T_A);
            7'd7:  i = mk(OP_MUL, T_A,   T_R2,  T_T);
            7'd8:  i = mk(OP_ADD, T_T,   S_K1,  T_A);
            7'd9:  i = mk(OP_MUL, T_A,   T_R2,  T_T);
            7'd10: i = mk(OP_ADD, T_KR,  S_ONE, T_A);
            7'd11: i = mk(OP_MUL, T_A,   S_K2,  T_R2);
            7'd12: i = mk(OP_MUL, T_A,   S_C2,  T_A);
            7'd13: i = mk(OP_MUL, T_B,   S_K3,  T_R4);
            7'd14: i = mk(OP_MUL, T_B,   S_C3,  T_B);
            7'd15: i = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd16: i = mk(OP_ADD, T_DKR, S_K1,  T_A);
            7'd17: i = mk(OP_MUL, T_A,   T_X2,  T_DKR);
            7'd18: i = mk(OP_MUL, T_A,   S_C2,  T_A);
            7'd19: i = mk(OP_ADD, T_A,   T_KR,  T_A);
            7'd20: i = mk(OP_MUL, T_B,   S_P2,  S_X);
            7'd21: i = mk(OP_MUL, T_B,   S_C6,  T_B);
            7'd22: i = mk(OP_MUL, T_C,   S_P1,  S_Y);
            7'd23: i = mk(OP_MUL, T_C,   S_C2,  T_C);
            7'd24: i = mk(OP_ADD, T_B,   T_B,   T_C);
            7'd25: i = mk(OP_ADD, T_JA,  T_A,   T_B);
            7'd26: i = mk(OP_MUL, T_A,   T_XY,  T_DKR);
            7'd27: i = mk(OP_MUL, T_A,   S_C2,  T_A);
            7'd28: i = mk(OP_MUL, T_B,   S_P1,  S_X);
            7'd29: i = mk(OP_MUL, T_B,   S_C2,  T_B);
            7'd30: i = mk(OP_MUL, T_C,   S_P2,  S_Y);
            7'd31: i = mk(OP_MUL, T_C,   S_C2,  T_C);
            7'd32: i = mk(OP_ADD, T_B,   T_B,   T_C);
            7'd33: i = mk(OP_ADD, T_JB,  T_A,   T_B);
            7'd34: i = mk(OP_MUL, T_A,   T_Y2,  T_DKR);
            7'd35: i = mk(OP_MUL, T_A,   S_C2,  T_A);
            7'd36: i = mk(OP_ADD, T_A,   T_KR,  T_A);
            7'd37: i = mk(OP_MUL, T_B,   S_P2,  S_X);
            7'd38: i = mk(OP_MUL, T_B,   S_C2,  T_B);
            7'd39: i = mk(OP_MUL, T_C,   S_P1,  S_Y);
            7'd40: i = mk(OP_MUL, T_C,   S_C6,  T_C);
            7'd41: i = mk(OP_ADD, T_B,   T_B,   T_C);
            7'd42: i = mk(OP_ADD, T_JD,  T_A,   T_B);
            7'd43: i = mk(OP_MUL, T_A,   S_X,   T_KR);
            7'd44: i = mk(OP_MUL, T_B,   S_C2,  T_X2);
            7'd45: i = mk(OP_ADD, T_B,   T_R2,  T_B);
            7'd46: i = mk(OP_MUL, T_B,   S_P2,  T_B);
            7'd47: i = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd48: i = mk(OP_MUL, T_B,   S_P1,  T_XY);
            7'd49: i = mk(OP_MUL, T_B,   S_C2,  T_B);
            7'd50: i = mk(OP_SUB, T_B,   T_B,   S_X0);
            7'd51: i = mk(OP_ADD, T_F,   T_A,   T_B);
            7'd52: i = mk(OP_MUL, T_A,   S_Y,   T_KR);
            7'd53: i = mk(OP_MUL, T_B,   S_C2,  T_Y2);
            7'd54: i = mk(OP_ADD, T_B,   T_R2,  T_B);
            7'd55: i = mk(OP_MUL, T_B,   S_P1,  T_B);
            7'd56: i = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd57: i = mk(OP_MUL, T_B,   S_P2,  T_XY);
            7'd58: i = mk(OP_MUL, T_B,   S_C2,  T_B);
            7'd59: i = mk(OP_SUB, T_B,   T_B,   S_Y0);
            7'd60: i = mk(OP_ADD, T_G,   T_A,   T_B);
            7'd61: i = mk(OP_MUL, T_A,   T_JA,  T_JD);
            7'd62: i = mk(OP_MUL, T_B,   T_JB,  T_JB);
            7'd63: i = mk(OP_SUB, T_DET, T_A,   T_B);
            7'd64: i = mk(OP_BRZ, T_A,   T_DET, T_DET);
            7'd65: i = mk(OP_MUL, T_A,   T_JD,  T_F);
            7'd66: i = mk(OP_MUL, T_B,   T_JB,  T_G);
            7'd67: i = mk(OP_SUB, T_A,   T_A,   T_B);
            7'd68: i = mk(OP_DIV, T_DX,  T_A,   T_DET);
            7'd69: i = mk(OP_MUL, T_A,   T_JA,  T_G);
            7'd70: i = mk(OP_MUL, T_B,   T_JB,  T_F);
            7'd71: i = mk(OP_SUB, T_A,   T_A,   T_B);
            7'd72: i = mk(OP_DIV, T_DY,  T_A,   T_DET);
            7'd73: i = mk(OP_UPD, T_A,   T_DX,  T_DY);
            default: i = mk(OP_UPD, T_A, T_DX,  T_DY);
        endcase
        return i;
    endfunction

endpackage

// ===== sv/lun_in_if.sv =====
// Input channel: one distorted coordinate pair per transaction.
// Depends on nothing.
interface lun_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
    modport source (output valid, output dist_x, output dist_y, input ready);
    modport sink   (input valid, input dist_x, input dist_y, output ready);
endinterface

// ===== sv/lun_out_if.sv =====
// Output channel: one undistorted pair with status per transaction.
// Depends on nothing.
interface lun_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] undist_x;
    logic signed [31:0] undist_y;
    logic               converged;
    logic [7:0]         iterations_used;
    modport source (output valid, output undist_x, output undist_y, output converged,
                    output iterations_used, input ready);
    modport sink   (input valid, input undist_x, input undist_y, input converged,
                    input iterations_used, output ready);
endinterface

// ===== sv/lun_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// Depends on nothing.
module lun_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ===== sv/lun_alu.sv =====
// Shared arithmetic unit: saturating Q.28 add/sub, 4-step multiply,
// 128-step restoring divide. Depends on lun_pkg.
module lun_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lun_pkg::t_alu_req i_req,
    output logic              o_done,
    output lun_pkg::t_val     o_res
);
    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_MFIN = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_DFIN = 3'd4;
    localparam logic [63:0] QLIM  = 64'h1FFF_FFFF_FFFF_FFFF;

    logic [2:0]     r_state;
    logic [61:0]    r_ma, r_mb;
    logic           r_neg;
    logic [127:0]   r_acc;
    logic [63:0]    r_pp;
    logic [1:0]     r_psh;
    logic           r_ppv;
    logic [2:0]     r_cnt;
    logic [127:0]   r_dvd;
    logic [63:0]    r_rem, r_ud, r_q;
    logic           r_sat;
    logic [6:0]     r_step;

    logic [63:0]    w_mag_a, w_mag_b;
    logic [31:0]    w_ai, w_bj;
    logic [63:0]    w_pp;
    logic [127:0]   w_ppsh;
    logic [63:0]    w_mmag, w_dmag;
    logic [63:0]    w_rs, w_rn;
    logic           w_ge;
    lun_pkg::t_val  w_sum, w_sat_sum;

    assign w_mag_a = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
    assign w_mag_b = i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);
    assign w_ai    = r_cnt[1] ? {2'b0, r_ma[61:32]} : r_ma[31:0];
    assign w_bj    = r_cnt[0] ? {2'b0, r_mb[61:32]} : r_mb[31:0];
    assign w_pp    = w_ai * w_bj;

    always_comb begin
        case (r_psh)
            2'd0:    w_ppsh = {64'b0, r_pp};
            2'd1:    w_ppsh = {32'b0, r_pp, 32'b0};
            default: w_ppsh = {r_pp, 64'b0};
        endcase
    end

    assign w_mmag = (|r_acc[127:90]) ? 64'(lun_pkg::WMAX) : {2'b0, r_acc[89:28]};
    assign w_dmag = r_sat ? 64'(lun_pkg::WMAX) : r_q;
    assign w_rs   = {r_rem[62:0], r_dvd[127]};
    assign w_ge   = w_rs >= r_ud;
    assign w_rn   = w_ge ? w_rs - r_ud : w_rs;

    always_comb begin
        w_sum = (i_req.op == lun_pkg::OP_SUB) ? i_req.a - i_req.b : i_req.a + i_req.b;
        if (w_sum > lun_pkg::WMAX) begin
            w_sat_sum = lun_pkg::WMAX;
        end else if (w_sum < -lun_pkg::WMAX) begin
            w_sat_sum = -lun_pkg::WMAX;
        end else begin
            w_sat_sum = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            o_done  <= 1'b0;
            r_ppv   <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_neg <= i_req.a[63] ^ i_req.b[63];
                        case (i_req.op)
                            lun_pkg::OP_MUL: begin
                                r_ma    <= w_mag_a[61:0];
                                r_mb    <= w_mag_b[61:0];
                                r_acc   <= '0;
                                r_cnt   <= '0;
                                r_ppv   <= 1'b0;
                                r_state <= A_MUL;
                            end
                            lun_pkg::OP_DIV: begin
                                r_dvd   <= {36'b0, w_mag_a, 28'b0};
                                r_ud    <= w_mag_b;
                                r_rem   <= '0;
                                r_q     <= '0;
                                r_sat   <= 1'b0;
                                r_step  <= '0;
                                r_state <= A_DIV;
                            end
                            default: begin
                                o_res  <= w_sat_sum;
                                o_done <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    if (r_ppv) begin
                        r_acc <= r_acc + w_ppsh;
                    end
                    if (r_cnt != 3'd4) begin
                        r_pp  <= w_pp;
                        r_psh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                        r_ppv <= 1'b1;
                        r_cnt <= r_cnt + 3'd1;
                    end else begin
                        r_ppv   <= 1'b0;
                        r_state <= A_MFIN;
                    end
                end
                A_MFIN: begin
                    o_res   <= r_neg ? -lun_pkg::t_val'(w_mmag) : lun_pkg::t_val'(w_mmag);
                    o_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    r_rem <= w_rn;
                    if (r_q > QLIM) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_q <= {r_q[62:0], w_ge};
                    end
                    r_dvd  <= {r_dvd[126:0], 1'b0};
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'd127) begin
                        r_state <= A_DFIN;
                    end
                end
                A_DFIN: begin
                    o_res   <= r_neg ? -lun_pkg::t_val'(w_dmag) : lun_pkg::t_val'(w_dmag);
                    o_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/lens_undistort_newton.sv =====
// Top level of the Newton lens undistortion block: config registers,
// microprogram sequencer, scratch RAM and shared ALU.
// Depends on lun_pkg, lun_in_if, lun_out_if, lun_ram, lun_alu.
//
// Usage: write the five Q7.24 coefficients and the stop threshold through
// i_cfg_we/i_cfg_idx/i_cfg_data while idle. Send a distorted Q3.28 pair on
// i_in; one transaction on o_out returns the undistorted pair, the converged
// flag and the iteration count.
// i_in.ready is high only while no item is in work or waiting on o_out.
// Each Newton iteration runs a 74-step microprogram on one shared ALU:
// 45 multiplies, 25 add/sub, two divides, the zero-determinant test and
// the update; an iteration ended by a zero determinant stops at the test
// and skips the rest of the microprogram. The bit-serial divider dominates.
// The block takes no new pair until the result has been taken.
// The result holds on o_out until o_out.ready; the next item is taken the
// cycle after.
// Reset: synchronous, active low; coefficients clear to 0, threshold to 1,
// the sequencer returns to idle.
module lens_undistort_newton (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lun_in_if.sink                i_in,
    lun_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  lun_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]         r_state;
    lun_pkg::t_pc       r_pc;
    logic signed [31:0] r_k1, r_k2, r_k3, r_p1, r_p2;
    logic [15:0]        r_thr;
    logic signed [31:0] r_x, r_y, r_x0, r_y0;
    logic [7:0]         r_used;
    logic               r_conv;

    lun_pkg::t_instr    w_ins;
    lun_pkg::t_val      w_ram_a, w_ram_b, w_opa, w_opb;
    lun_pkg::t_alu_req  w_req;
    logic               w_done;
    lun_pkg::t_val      w_res;
    lun_pkg::t_val      w_nxw, w_nyw;
    logic signed [31:0] w_nx, w_ny;
    logic signed [32:0] w_ddx, w_ddy;
    logic [32:0]        w_adx, w_ady;
    logic               w_conv;

    function automatic lun_pkg::t_val coef(logic signed [31:0] c);
        return {{28{c[31]}}, c, 4'b0};
    endfunction

    function automatic lun_pkg::t_val sx(logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(lun_pkg::t_val v);
        logic signed [31:0] s;
        if (v > 64'sd2147483647) begin
            s = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            s = 32'sh8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    function automatic lun_pkg::t_val pick(lun_pkg::t_src s, lun_pkg::t_val ram,
                                           lun_pkg::t_val x, lun_pkg::t_val y,
                                           lun_pkg::t_val x0, lun_pkg::t_val y0,
                                           lun_pkg::t_val k1, lun_pkg::t_val k2,
                                           lun_pkg::t_val k3, lun_pkg::t_val p1,
                                           lun_pkg::t_val p2);
        lun_pkg::t_val v;
        case (s)
            lun_pkg::S_X:   v = x;
            lun_pkg::S_Y:   v = y;
            lun_pkg::S_X0:  v = x0;
            lun_pkg::S_Y0:  v = y0;
            lun_pkg::S_K1:  v = k1;
            lun_pkg::S_K2:  v = k2;
            lun_pkg::S_K3:  v = k3;
            lun_pkg::S_P1:  v = p1;
            lun_pkg::S_P2:  v = p2;
            lun_pkg::S_ONE: v = lun_pkg::Q_ONE;
            lun_pkg::S_C2:  v = lun_pkg::Q_C2;
            lun_pkg::S_C3:  v = lun_pkg::Q_C3;
            lun_pkg::S_C6:  v = lun_pkg::Q_C6;
            default:        v = ram;
        endcase
        return v;
    endfunction

    assign w_ins = lun_pkg::prog(r_pc);

    lun_ram #(
        .WIDTH (64),
        .DEPTH (lun_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (r_state == S_WAIT && w_done),
        .i_waddr   (w_ins.dst),
        .i_wdata   (w_res),
        .i_raddr_a (w_ins.sa[lun_pkg::RAM_AW-1:0]),
        .i_raddr_b (w_ins.sb[lun_pkg::RAM_AW-1:0]),
        .o_rdata_a (w_ram_a),
        .o_rdata_b (w_ram_b)
    );

    assign w_opa = pick(w_ins.sa, w_ram_a, sx(r_x), sx(r_y), sx(r_x0), sx(r_y0),
                        coef(r_k1), coef(r_k2), coef(r_k3), coef(r_p1), coef(r_p2));
    assign w_opb = pick(w_ins.sb, w_ram_b, sx(r_x), sx(r_y), sx(r_x0), sx(r_y0),
                        coef(r_k1), coef(r_k2), coef(r_k3), coef(r_p1), coef(r_p2));

    always_comb begin
        w_req.start = (r_state == S_EXEC) && (w_ins.op != lun_pkg::OP_BRZ)
                      && (w_ins.op != lun_pkg::OP_UPD);
        w_req.op    = w_ins.op;
        w_req.a     = w_opa;
        w_req.b     = w_opb;
    end

    lun_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign w_nxw  = sx(r_x) - w_opa;
    assign w_nyw  = sx(r_y) - w_opb;
    assign w_nx   = sat32(w_nxw);
    assign w_ny   = sat32(w_nyw);
    assign w_ddx  = 33'(w_nx) - 33'(r_x);
    assign w_ddy  = 33'(w_ny) - 33'(r_y);
    assign w_adx  = w_ddx[32] ? 33'(-w_ddx) : 33'(w_ddx);
    assign w_ady  = w_ddy[32] ? 33'(-w_ddy) : 33'(w_ddy);
    assign w_conv = (w_adx <= {17'b0, r_thr}) && (w_ady <= {17'b0, r_thr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1  <= '0;
            r_k2  <= '0;
            r_k3  <= '0;
            r_p1  <= '0;
            r_p2  <= '0;
            r_thr <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lun_pkg::CFG_K1:  r_k1  <= i_cfg_data;
                lun_pkg::CFG_K2:  r_k2  <= i_cfg_data;
                lun_pkg::CFG_K3:  r_k3  <= i_cfg_data;
                lun_pkg::CFG_P1:  r_p1  <= i_cfg_data;
                lun_pkg::CFG_P2:  r_p2  <= i_cfg_data;
                lun_pkg::CFG_THR: r_thr <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_used  <= '0;
            r_conv  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x0    <= i_in.dist_x;
                        r_y0    <= i_in.dist_y;
                        r_x     <= i_in.dist_x;
                        r_y     <= i_in.dist_y;
                        r_pc    <= '0;
                        r_used  <= '0;
                        r_conv  <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_EXEC;
                S_EXEC: begin
                    case (w_ins.op)
                        lun_pkg::OP_BRZ: begin
                            r_used <= r_used + 8'd1;
                            if (w_opa == '0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_pc    <= r_pc + 7'd1;
                                r_state <= S_FETCH;
                            end
                        end
                        lun_pkg::OP_UPD: begin
                            r_x <= w_nx;
                            r_y <= w_ny;
                            if (w_conv) begin
                                r_conv  <= 1'b1;
                                r_state <= S_OUT;
                            end else if (r_used == 8'(lun_pkg::ITER_LIMIT)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_pc    <= '0;
                                r_state <= S_FETCH;
                            end
                        end
                        default: r_state <= S_WAIT;
                    endcase
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_pc    <= r_pc + 7'd1;
                        r_state <= S_FETCH;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = (r_state == S_OUT);
    assign o_out.undist_x        = r_x;
    assign o_out.undist_y        = r_y;
    assign o_out.converged       = r_conv;
    assign o_out.iterations_used = r_used;
endmodule

// ===== test/lun_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Newton lens undistortion block: watches the config port and both
// channels, predicts each result in fixed point and compares it field by field.
// Depends on lun_pkg, lun_in_if, lun_out_if.
module lun_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lun_in_if                 mon_in,
    lun_out_if                mon_out,
    input  logic              i_cfg_we,
    input  lun_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    typedef struct {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic               conv;
        logic [7:0]         iters;
    } t_undist;

    logic signed [31:0] coef_k1, coef_k2, coef_k3, coef_p1, coef_p2;
    logic [15:0]        thr;
    t_undist            undist_q[$];
    int                 err_cnt = 0;

    function automatic lun_pkg::t_val sat_add(lun_pkg::t_val a, lun_pkg::t_val b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, lun_pkg::WMAX})) return lun_pkg::WMAX;
        if (s < -$signed({1'b0, lun_pkg::WMAX})) return -lun_pkg::WMAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] magn(lun_pkg::t_val v);
        return v < 0 ? -v : v;
    endfunction

    function automatic lun_pkg::t_val mul_q(lun_pkg::t_val a, lun_pkg::t_val b);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        p = p >> 28;
        m = (p > {64'd0, lun_pkg::WMAX}) ? lun_pkg::WMAX : p[63:0];
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic lun_pkg::t_val div_q(lun_pkg::t_val n, lun_pkg::t_val d);
        logic [127:0] q;
        logic [63:0]  m;
        q = ({64'd0, magn(n)} << 28) / {64'd0, magn(d)};
        m = (q > {64'd0, lun_pkg::WMAX}) ? lun_pkg::WMAX : q[63:0];
        return ((n < 0) != (d < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic lun_pkg::t_val sat32(lun_pkg::t_val v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_undist undistort(logic signed [31:0] dx_in, logic signed [31:0] dy_in);
        lun_pkg::t_val k1, k2, k3, p1, p2, x0, y0, x, y, tv, thv;
        lun_pkg::t_val x2, y2, xy, r2, r4, kr, dkr, ja, jb, jd, f, g, det, sx, sy, nx, ny;
        t_undist r;
        int it;
        logic conv;
        logic [7:0] used;
        k1 = lun_pkg::t_val'(coef_k1) * 16;
        k2 = lun_pkg::t_val'(coef_k2) * 16;
        k3 = lun_pkg::t_val'(coef_k3) * 16;
        p1 = lun_pkg::t_val'(coef_p1) * 16;
        p2 = lun_pkg::t_val'(coef_p2) * 16;
        x0 = lun_pkg::t_val'(dx_in);
        y0 = lun_pkg::t_val'(dy_in);
        x = x0;
        y = y0;
        thv = lun_pkg::t_val'({48'd0, thr});
        conv = 1'b0;
        used = 8'd0;
        for (it = 0; it < lun_pkg::ITER_LIMIT; it++) begin
            x2 = mul_q(x, x);
            y2 = mul_q(y, y);
            xy = mul_q(x, y);
            r2 = sat_add(x2, y2);
            r4 = mul_q(r2, r2);
            tv = sat_add(k2, mul_q(r2, k3));
            tv = sat_add(k1, mul_q(r2, tv));
            kr = sat_add(lun_pkg::Q_ONE, mul_q(r2, tv));
            dkr = sat_add(k1, sat_add(mul_q(lun_pkg::Q_C2, mul_q(k2, r2)),
                                      mul_q(lun_pkg::Q_C3, mul_q(k3, r4))));
            ja = sat_add(sat_add(kr, mul_q(lun_pkg::Q_C2, mul_q(x2, dkr))),
                         sat_add(mul_q(lun_pkg::Q_C6, mul_q(p2, x)),
                                 mul_q(lun_pkg::Q_C2, mul_q(p1, y))));
            jb = sat_add(mul_q(lun_pkg::Q_C2, mul_q(xy, dkr)),
                         sat_add(mul_q(lun_pkg::Q_C2, mul_q(p1, x)),
                                 mul_q(lun_pkg::Q_C2, mul_q(p2, y))));
            jd = sat_add(sat_add(kr, mul_q(lun_pkg::Q_C2, mul_q(y2, dkr))),
                         sat_add(mul_q(lun_pkg::Q_C2, mul_q(p2, x)),
                                 mul_q(lun_pkg::Q_C6, mul_q(p1, y))));
            f = sat_add(sat_add(mul_q(x, kr),
                                mul_q(p2, sat_add(r2, mul_q(lun_pkg::Q_C2, x2)))),
                        sat_add(mul_q(lun_pkg::Q_C2, mul_q(p1, xy)), -x0));
            g = sat_add(sat_add(mul_q(y, kr),
                                mul_q(p1, sat_add(r2, mul_q(lun_pkg::Q_C2, y2)))),
                        sat_add(mul_q(lun_pkg::Q_C2, mul_q(p2, xy)), -y0));
            det = sat_add(mul_q(ja, jd), -mul_q(jb, jb));
            used = 8'(it + 1);
            if (det == 0) break;
            sx = div_q(sat_add(mul_q(jd, f), -mul_q(jb, g)), det);
            sy = div_q(sat_add(mul_q(ja, g), -mul_q(jb, f)), det);
            nx = sat32(sat_add(x, -sx));
            ny = sat32(sat_add(y, -sy));
            conv = magn(nx - x) <= thv && magn(ny - y) <= thv;
            x = nx;
            y = ny;
            if (conv) break;
        end
        r.ux = x[31:0];
        r.uy = y[31:0];
        r.conv = conv;
        r.iters = used;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    assign o_errors = err_cnt;
    assign o_pending = undist_q.size();

    always @(posedge i_clk) begin
        t_undist w;
        if (!i_rst_n) begin
            coef_k1 <= '0;
            coef_k2 <= '0;
            coef_k3 <= '0;
            coef_p1 <= '0;
            coef_p2 <= '0;
            thr     <= 16'd1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lun_pkg::CFG_K1:  coef_k1 <= i_cfg_data;
                    lun_pkg::CFG_K2:  coef_k2 <= i_cfg_data;
                    lun_pkg::CFG_K3:  coef_k3 <= i_cfg_data;
                    lun_pkg::CFG_P1:  coef_p1 <= i_cfg_data;
                    lun_pkg::CFG_P2:  coef_p2 <= i_cfg_data;
                    lun_pkg::CFG_THR: thr     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (mon_in.valid && mon_in.ready)
                undist_q.insert(undist_q.size(), undistort(mon_in.dist_x, mon_in.dist_y));
            if (mon_out.valid && mon_out.ready) begin
                if (undist_q.size() == 0) begin
                    report("unexpected result", mon_out.undist_x, 32'd0);
                end else begin
                    w = undist_q.pop_front();
                    if (mon_out.undist_x !== w.ux) report("undist_x", mon_out.undist_x, w.ux);
                    if (mon_out.undist_y !== w.uy) report("undist_y", mon_out.undist_y, w.uy);
                    if (mon_out.converged !== w.conv)
                        report("converged", 32'(mon_out.converged), 32'(w.conv));
                    if (mon_out.iterations_used !== w.iters)
                        report("iterations_used", 32'(mon_out.iterations_used), 32'(w.iters));
                end
            end
        end
    end
endmodule

// ===== test/tb_lens_undistort_newton.sv =====
`timescale 1ns / 1ps
// Testbench top for the Newton lens undistortion block: clock, reset, config writes,
// directed and random coordinate pairs, random back-pressure and the verdict.
// Depends on lun_pkg, lun_in_if, lun_out_if, lens_undistort_newton, lun_checker.
module tb_lens_undistort_newton;
    localparam int SPAN = 188000000;
    localparam int ONE28 = 268435456;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    lun_pkg::t_cfg_idx cfg_idx = lun_pkg::CFG_K1;
    logic [31:0]       cfg_data = '0;
    int                errors;
    int                pending;
    int                sent = 0;
    int                results = 0;
    logic              burst;
    logic              held = 1'b0;

    lun_in_if  in_ch();
    lun_out_if out_ch();

    lens_undistort_newton uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    lun_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .mon_in(in_ch), .mon_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    assign burst = sent >= 450 && sent < 600;

    always @(posedge i_clk)
        if (out_ch.valid && out_ch.ready) results++;

    initial begin
        #2000000000;
        $display("[lens_undistort_newton] ERROR");
        $finish;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results >= 300) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
            end
            out_ch.ready <= burst || $urandom_range(0, 99) >= 37;
        end
    end

    function automatic logic [31:0] rnd_span(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic write_reg(lun_pkg::t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                             logic [31:0] p1, logic [31:0] p2, logic [15:0] t);
        write_reg(lun_pkg::CFG_K1, k1);
        write_reg(lun_pkg::CFG_K2, k2);
        write_reg(lun_pkg::CFG_K3, k3);
        write_reg(lun_pkg::CFG_P1, p1);
        write_reg(lun_pkg::CFG_P2, p2);
        write_reg(lun_pkg::CFG_THR, {16'd0, t});
    endtask

    task automatic send_pair(logic [31:0] x, logic [31:0] y);
        @(negedge i_clk);
        while (!burst && $urandom_range(0, 99) < 37) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.dist_x <= x;
        in_ch.dist_y <= y;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        int ph;
        int n;
        logic [31:0] x;
        logic [31:0] y;
        in_ch.valid  <= 1'b0;
        in_ch.dist_x <= '0;
        in_ch.dist_y <= '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: identity model, threshold one
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h0000_0001, 32'hFFFF_FFFF);
        drain();

        write_all(32'd3355443, -32'sd838861, 32'd167772, 32'd16777, -32'sd33554, 16'd0);
        send_pair(32'd134217728, 32'd80530637);
        send_pair(32'h0000_0000, 32'h0000_0000);
        drain();

        // zero determinant: k1 = -1 at x = 1.0, y = 0
        write_all(-32'sd16777216, 32'd0, 32'd0, 32'd0, 32'd0, 16'd65535);
        send_pair(ONE28, 32'd0);
        drain();

        write_all(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 16'd65535);
        send_pair(32'd134217728, -32'sd134217728);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 16'd65535);
        send_pair(32'd100000000, 32'd50000000);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        write_reg(lun_pkg::t_cfg_idx'(6), 32'hFFFF_FFFF);
        write_reg(lun_pkg::t_cfg_idx'(7), 32'hFFFF_FFFF);

        for (ph = 0; ph < 6; ph++) begin
            if (ph == 0)
                write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'($urandom_range(0, 65535)));
            else
                write_all(rnd_span(8388608), rnd_span(4194304), rnd_span(2097152),
                          rnd_span(1048576), rnd_span(1048576),
                          ph == 5 ? 16'd65535 : 16'($urandom_range(8, 4096)));
            for (n = 0; n < 175; n++) begin
                if (ph == 0) begin
                    x = $urandom;
                    y = $urandom;
                end else if ($urandom_range(0, 9) == 0) begin
                    x = rnd_span(ONE28);
                    y = rnd_span(ONE28);
                end else begin
                    x = rnd_span(SPAN);
                    y = rnd_span(SPAN);
                end
                send_pair(x, y);
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("[lens_undistort_newton] OK");
        else
            $display("[lens_undistort_newton] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/lun_pkg.sv
sv/lun_in_if.sv
sv/lun_out_if.sv
sv/lun_ram.sv
sv/lun_alu.sv
sv/lens_undistort_newton.sv
test/lun_checker.sv
test/tb_lens_undistort_newton.sv
